// ----- hw/rtl/gso_pkg.sv -----
// gso_pkg: shared types and constants of the glyph shadow outline block
// no dependencies; imported by the interfaces and every module

`default_nettype none

package gso_pkg;

	localparam int WORD_W  = 32;
	localparam int NIB_W   = 4;
	localparam int NIBS    = WORD_W / NIB_W;
	localparam int ROWS    = 32;
	localparam int ROW_W   = $clog2(ROWS);
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [ROW_W-1:0] ROW_TL_LAST  = ROW_W'(7);
	localparam logic [ROW_W-1:0] ROW_TR_LAST  = ROW_W'(15);
	localparam logic [ROW_W-1:0] ROW_BL_FIRST = ROW_W'(16);
	localparam logic [ROW_W-1:0] ROW_BL_LAST  = ROW_W'(23);
	localparam logic [ROW_W-1:0] ROW_BR_FIRST = ROW_W'(24);
	localparam logic [ROW_W-1:0] ROW_BR_LAST  = ROW_W'(31);

	localparam int TILE_ROWS = 8;
	localparam int TAP_SAME  = TILE_ROWS;
	localparam int TAP_NEXT  = TILE_ROWS + 1;
	localparam int TAP_CORNER = int'(ROW_BR_FIRST) - int'(ROW_TL_LAST);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [NIB_W-1:0]  nib_t;

	typedef struct packed {
		word_t word;
		logic  nz0;
	} gso_entry_t;

	typedef enum logic {
		BK_LOAD,
		BK_EMIT
	} gso_bk_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gso_if.sv -----
// gso_if: valid/ready channels of the block (glyph rows, shaded rows, colour write)
// depends on gso_pkg

`default_nettype none

interface gso_row_if;
	import gso_pkg::*;
	logic  valid;
	logic  ready;
	word_t row_word;
	modport source (output valid, output row_word, input ready);
	modport sink (input valid, input row_word, output ready);
endinterface

interface gso_out_if;
	import gso_pkg::*;
	logic  valid;
	logic  ready;
	word_t shaded_word;
	logic  last_row;
	modport source (output valid, output shaded_word, output last_row, input ready);
	modport sink (input valid, input shaded_word, input last_row, output ready);
endinterface

interface gso_cfg_if;
	import gso_pkg::*;
	logic valid;
	logic ready;
	nib_t shade_color;
	modport source (output valid, output shade_color, input ready);
	modport sink (input valid, input shade_color, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gso_front.sv -----
// gso_front: takes row beats, tags each with its leftmost-pixel flag, holds the colour register
// depends on gso_pkg and gso_if

`default_nettype none

module gso_front (
	input  wire                 clk,
	input  wire                 arst_n,
	gso_row_if.sink             glyph,
	gso_cfg_if.sink             cfg,
	output gso_pkg::gso_entry_t push_data,
	output logic                push_valid,
	input  wire                 push_ready,
	output gso_pkg::nib_t       shade
);
	import gso_pkg::*;

	nib_t shade_q;

	assign cfg.ready   = 1'b1;
	assign glyph.ready = push_ready;
	assign push_valid  = glyph.valid;
	assign shade       = shade_q;

	always_comb begin
		push_data.word = glyph.row_word;
		push_data.nz0  = (glyph.row_word[NIB_W-1:0] != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shade_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			shade_q <= cfg.shade_color;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/gso_queue.sv -----
// gso_queue: short queue of tagged rows between front and back
// depends on gso_pkg

`default_nettype none

module gso_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push_valid,
	input  gso_pkg::gso_entry_t push_data,
	output logic                push_ready,
	output logic                pop_valid,
	output gso_pkg::gso_entry_t pop_data,
	input  wire                 pop_ready
);
	import gso_pkg::*;

	gso_entry_t          slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/gso_back.sv -----
// gso_back: glyph store, load sequencer and one-row-per-cycle recolouring of stored glyphs unless the output stalls
// depends on gso_pkg and gso_if

`default_nettype none

module gso_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 pop_valid,
	input  gso_pkg::gso_entry_t pop_data,
	output logic                pop_ready,
	input  gso_pkg::nib_t       shade,
	gso_out_if.source           shaded
);
	import gso_pkg::*;

	gso_bk_state_t    state_q, state_d;
	logic [ROW_W-1:0] cnt_q;
	logic [ROWS-1:0]  flags_q;
	word_t            store_q [ROWS];

	word_t            own_s1;
	word_t            blw_s1;
	logic             hb_s1;
	logic             same_s1;
	logic             next_s1;
	logic             last_s1;
	logic             v_s1;

	logic             do_pop;
	logic             adv;
	logic             issue;
	logic [ROW_W-1:0] blw_addr;
	logic             hb;
	logic             left_row;
	logic             same_hit;
	logic             next_hit;
	nib_t             body;
	nib_t             shadow;
	word_t            colored;

	assign pop_ready = (state_q == BK_LOAD);
	assign do_pop    = pop_valid && pop_ready;
	assign adv       = !v_s1 || shaded.ready;
	assign issue     = (state_q == BK_EMIT) && adv;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_LOAD: begin
				if (do_pop && cnt_q == ROW_BR_LAST) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (issue && cnt_q == ROW_BR_LAST) begin
					state_d = BK_LOAD;
				end
			end
			default: state_d = BK_LOAD;
		endcase
	end

	always_comb begin
		hb       = 1'b1;
		blw_addr = cnt_q + ROW_W'(1);
		case (cnt_q)
			ROW_TL_LAST: blw_addr = ROW_BL_FIRST;
			ROW_TR_LAST: blw_addr = ROW_BR_FIRST;
			ROW_BL_LAST: hb = 1'b0;
			ROW_BR_LAST: hb = 1'b0;
			default:     hb = 1'b1;
		endcase
		left_row = cnt_q inside {[ROW_W'(0):ROW_TL_LAST - ROW_W'(1)],
		                         [ROW_BL_FIRST:ROW_BL_LAST - ROW_W'(1)]};
		same_hit = left_row && flags_q[TAP_SAME];
		next_hit = (left_row && flags_q[TAP_NEXT])
		        || (cnt_q == ROW_TL_LAST && flags_q[TAP_CORNER]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_LOAD;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_pop || issue) begin
				cnt_q <= cnt_q + ROW_W'(1);
			end
			if (adv) begin
				v_s1 <= issue;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			store_q[cnt_q] <= pop_data.word;
			flags_q        <= {pop_data.nz0, flags_q[ROWS-1:1]};
		end else if (issue) begin
			flags_q        <= {1'b0, flags_q[ROWS-1:1]};
		end
		if (issue) begin
			own_s1  <= store_q[cnt_q];
			blw_s1  <= store_q[blw_addr];
			hb_s1   <= hb;
			same_s1 <= same_hit;
			next_s1 <= next_hit;
			last_s1 <= (cnt_q == ROW_BR_LAST);
		end
	end

	// recolour from the registered rows
	always_comb begin
		nib_t down;
		nib_t spread;
		body    = shade;
		shadow  = shade + NIB_W'(1);
		colored = '0;
		for (int j = 0; j < NIBS - 1; j++) begin
			down   = hb_s1 ? blw_s1[NIB_W*(j+1) +: NIB_W] : '0;
			spread = own_s1[NIB_W*j +: NIB_W] | own_s1[NIB_W*(j+1) +: NIB_W];
			if (down != '0) begin
				colored[NIB_W*j +: NIB_W] = shadow;
			end else if (spread != '0) begin
				colored[NIB_W*j +: NIB_W] = body;
			end
		end
		if (next_s1) begin
			colored[WORD_W-1 -: NIB_W] = shadow;
		end else if (same_s1 || own_s1[WORD_W-1 -: NIB_W] != '0) begin
			colored[WORD_W-1 -: NIB_W] = body;
		end
		if (body == '0) begin
			colored = own_s1;
		end
	end

	assign shaded.valid       = v_s1;
	assign shaded.shaded_word = colored;
	assign shaded.last_row    = last_s1;

endmodule

`default_nettype wire

// ----- hw/rtl/glyph_shadow_outline.sv -----
// glyph_shadow_outline: top level, front, queue and back of the glyph recolouring block
// depends on gso_pkg, gso_if, gso_front, gso_queue, gso_back

// A glyph is 32 row beats (four 8x8 tiles: top-left, top-right, bottom-left,
// bottom-right). Rows are written one per cycle while loading into a single
// 32-word store; once the 32nd is in, the store is read at two ports (own row,
// row below) and one recoloured row leaves per cycle unless the output stalls,
// last_row marking the 32nd. The store is shared by load and emission: the
// next glyph loads only after the last row of the current one is issued. A
// two-beat queue in front lets the next glyph start arriving during emission.
// shade_color is used at emission time; zero passes rows through unchanged.

`default_nettype none

module glyph_shadow_outline (
	input  wire       clk,
	input  wire       arst_n,
	gso_row_if.sink   glyph,
	gso_cfg_if.sink   cfg,
	gso_out_if.source shaded
);
	import gso_pkg::*;

	gso_entry_t push_data;
	logic       push_valid;
	logic       push_ready;
	gso_entry_t pop_data;
	logic       pop_valid;
	logic       pop_ready;
	nib_t       shade;

	gso_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.glyph      (glyph),
		.cfg        (cfg),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.shade      (shade)
	);

	gso_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	gso_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.shade     (shade),
		.shaded    (shaded)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/gso_checker.sv -----
// gso_checker: port-level checks on row counting and glyph ordering, bound to the top level
// depends on gso_pkg and glyph_shadow_outline

`default_nettype none

module gso_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                in_valid,
	input wire                in_ready,
	input wire                out_valid,
	input wire                out_ready,
	input wire [gso_pkg::WORD_W-1:0] out_word,
	input wire                out_last
);
	import gso_pkg::*;

	logic [ROW_W-1:0] in_row_q;
	logic [ROW_W-1:0] out_row_q;
	logic [2:0]       pend_q;
	logic             in_beat;
	logic             out_beat;
	logic             glyph_in;
	logic             glyph_out;

	assign in_beat   = in_valid && in_ready;
	assign out_beat  = out_valid && out_ready;
	assign glyph_in  = in_beat && in_row_q == ROW_BR_LAST;
	assign glyph_out = out_beat && out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			out_row_q <= '0;
			pend_q    <= '0;
		end else begin
			if (in_beat) begin
				in_row_q <= in_row_q + ROW_W'(1);
			end
			if (out_beat) begin
				out_row_q <= out_row_q + ROW_W'(1);
			end
			case ({glyph_in, glyph_out})
				2'b10:   pend_q <= pend_q + 3'd1;
				2'b01:   pend_q <= pend_q - 3'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
		else $error("stalled result beat changed");

	a_last_place: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> (out_last == (out_row_q == ROW_BR_LAST)))
		else $error("last_row not on the 32nd row of a glyph");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("result beat before a whole glyph was taken");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd2)
		else $error("too many glyphs held");

endmodule

bind glyph_shadow_outline gso_checker u_gso_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (glyph.valid),
	.in_ready  (glyph.ready),
	.out_valid (shaded.valid),
	.out_ready (shaded.ready),
	.out_word  (shaded.shaded_word),
	.out_last  (shaded.last_row)
);

`default_nettype wire

// ----- bench/tb_glyph_shadow_outline.sv -----
// tb_glyph_shadow_outline: self-checking bench for the glyph recolouring block
// depends on gso_pkg, gso_if and glyph_shadow_outline; drives whole glyphs under
// several colour settings and checks every shaded row against a predicted row

`default_nettype none

module tb_glyph_shadow_outline;
	import gso_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 40;
	localparam int IDLE_PCT    = 13;

	typedef struct {
		word_t word;
		logic  last;
	} row_beat_t;

	class shade_board;
		word_t       store [ROWS];
		int unsigned fill;
		nib_t        colour;
		row_beat_t   due [$];
		int unsigned emitted;
		int          errors;

		function new();
			fill = 0;
			colour = '0;
			emitted = 0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("tb: mismatch at shaded row %0d: %s", emitted, msg);
			errors++;
		endtask

		function word_t recolour(word_t own, word_t below, bit has_below, nib_t body,
				nib_t shadow);
			word_t spread;
			word_t drop;
			word_t res;
			spread = own | (own >> NIB_W);
			drop = has_below ? (below >> NIB_W) : '0;
			res = '0;
			for (int j = 0; j < NIBS; j++) begin
				if (drop[j*NIB_W +: NIB_W] != '0)
					res[j*NIB_W +: NIB_W] = shadow;
				else if (spread[j*NIB_W +: NIB_W] != '0)
					res[j*NIB_W +: NIB_W] = body;
			end
			return res;
		endfunction

		// one accepted glyph row; the 32nd row releases the whole shaded glyph
		function void note_row(word_t w);
			word_t     res [ROWS];
			nib_t      body;
			nib_t      shadow;
			int        below;
			row_beat_t b;
			store[fill] = w;
			fill = (fill + 1) % ROWS;
			if (fill != 0)
				return;
			body = colour;
			shadow = body + nib_t'(1);
			for (int r = 0; r < ROWS; r++) begin
				if (body == '0) begin
					res[r] = store[r];
				end else begin
					if (r == int'(ROW_TL_LAST))
						below = int'(ROW_BL_FIRST);
					else if (r == int'(ROW_TR_LAST))
						below = int'(ROW_BR_FIRST);
					else if (r == int'(ROW_BL_LAST) || r == int'(ROW_BR_LAST))
						below = -1;
					else
						below = r + 1;
					res[r] = recolour(store[r], below >= 0 ? store[below] : '0,
						below >= 0, body, shadow);
				end
			end
			if (body != '0) begin
				// left tile edge pixel looks into the right tile
				for (int r = 0; r < int'(ROW_BL_LAST); r++) begin
					if (r >= int'(ROW_TL_LAST) && r <= int'(ROW_TR_LAST))
						continue;
					if (store[r + TAP_SAME][NIB_W-1:0] != '0)
						res[r][WORD_W-1 -: NIB_W] = body;
					if (store[r + TAP_NEXT][NIB_W-1:0] != '0)
						res[r][WORD_W-1 -: NIB_W] = shadow;
				end
				if (store[ROW_BR_FIRST][NIB_W-1:0] != '0)
					res[ROW_TL_LAST][WORD_W-1 -: NIB_W] = shadow;
			end
			for (int r = 0; r < ROWS; r++) begin
				b.word = res[r];
				b.last = (r == ROWS - 1);
				due.push_back(b);
			end
		endfunction

		task check_beat(word_t w, logic last);
			row_beat_t want;
			if (due.size() == 0) begin
				report($sformatf("unexpected row %h", w));
			end else begin
				want = due.pop_front();
				if (w !== want.word)
					report($sformatf("word %h, predicted %h", w, want.word));
				if (last !== want.last)
					report($sformatf("last_row %b, predicted %b", last, want.last));
			end
			emitted++;
		endtask

		task flush_check();
			if (due.size() != 0)
				report($sformatf("%0d predicted rows never emitted", due.size()));
			due.delete();
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	bit          steady;
	int unsigned cycles;
	word_t       glyph_rows [ROWS];
	shade_board  board;

	gso_row_if glyph_if ();
	gso_cfg_if cfg_if ();
	gso_out_if shaded_if ();

	glyph_shadow_outline uut (
		.clk    (clk),
		.arst_n (arst_n),
		.glyph  (glyph_if),
		.cfg    (cfg_if),
		.shaded (shaded_if)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (glyph_if.valid && glyph_if.ready)
			board.note_row(glyph_if.row_word);
		if (cfg_if.valid && cfg_if.ready)
			board.colour = cfg_if.shade_color;
		if (shaded_if.valid && shaded_if.ready)
			board.check_beat(shaded_if.shaded_word, shaded_if.last_row);
	end

	always @(negedge clk)
		shaded_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

	initial begin
		while (cycles < CYCLE_LIMIT)
			@(posedge clk);
		$display("tb: failure");
		$finish;
	end

	function automatic word_t random_row();
		int unsigned pick;
		word_t       w;
		pick = $urandom_range(0, 99);
		w = '0;
		if (pick < 8) begin
			w = $urandom;
		end else if (pick < 12) begin
			w = '0;
		end else if (pick < 16) begin
			w = '1;
		end else begin
			for (int j = 0; j < NIBS; j++)
				if ($urandom_range(0, 99) < 40)
					w[j*NIB_W +: NIB_W] = nib_t'($urandom_range(1, 15));
		end
		return w;
	endfunction

	task push_row(word_t w);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			glyph_if.valid <= 1'b0;
			glyph_if.row_word <= $urandom;
			@(negedge clk);
		end
		glyph_if.valid <= 1'b1;
		glyph_if.row_word <= w;
		do
			@(posedge clk);
		while (!glyph_if.ready);
	endtask

	task send_glyph();
		for (int r = 0; r < ROWS; r++)
			push_row(glyph_rows[r]);
	endtask

	task fill_random_glyph();
		for (int r = 0; r < ROWS; r++)
			glyph_rows[r] = random_row();
	endtask

	task write_colour(nib_t c);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.shade_color <= c;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task settle();
		@(negedge clk);
		glyph_if.valid <= 1'b0;
		while (board.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		board = new();
		cycles = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		glyph_if.valid = 1'b0;
		glyph_if.row_word = '0;
		cfg_if.valid = 1'b0;
		cfg_if.shade_color = '0;
		shaded_if.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// pass through with extreme rows
		write_colour(nib_t'(0));
		fill_random_glyph();
		glyph_rows[0] = '0;
		glyph_rows[1] = '1;
		glyph_rows[2] = 32'h5555_5555;
		glyph_rows[3] = 32'hAAAA_AAAA;
		glyph_rows[4] = 32'h0000_000F;
		glyph_rows[5] = 32'hF000_0000;
		send_glyph();
		settle();

		// shadow index wraps to zero
		write_colour(nib_t'(15));
		fill_random_glyph();
		glyph_rows[0] = '1;
		glyph_rows[ROW_BR_FIRST] = '1;
		send_glyph();
		settle();

		// sparse pixels on the tile seams
		write_colour(nib_t'(1));
		for (int r = 0; r < ROWS; r++)
			glyph_rows[r] = '0;
		glyph_rows[3]  = 32'h0000_0010;
		glyph_rows[10] = 32'h0000_0001;
		glyph_rows[12] = 32'h0000_0001;
		glyph_rows[13] = 32'h0000_0001;
		glyph_rows[7]  = 32'h1000_0000;
		glyph_rows[15] = 32'h8000_0000;
		glyph_rows[16] = 32'h0000_0100;
		glyph_rows[23] = 32'h0000_1000;
		glyph_rows[24] = 32'h0000_0011;
		glyph_rows[30] = 32'h0000_0001;
		glyph_rows[31] = 32'h0000_0001;
		send_glyph();
		settle();

		for (int p = 0; p < 5; p++) begin
			if (p == 0)
				write_colour(nib_t'(14));
			else if (p == 3)
				write_colour(nib_t'(0));
			else
				write_colour(nib_t'($urandom_range(1, 15)));
			steady = (p == 2);
			for (int g = 0; g < ((p == 2) ? 2 : 1); g++) begin
				fill_random_glyph();
				send_glyph();
			end
			settle();
		end
		steady = 1'b0;

		board.flush_check();
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
